@@ hdl/uts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uts_pkg
// Types, character codes and classification helpers for the token scanner.
// ----------------------------------------------------------------------------
package uts_pkg;

    localparam int LINE_BITS       = 16;
    localparam int UNIT_COUNT_BITS = 8;
    localparam int CODE_W          = 21;
    localparam int LINE_OUT_W      = 16;
    localparam int UNIT_OUT_W      = 8;
    localparam int MAX_RES         = 4;
    localparam int CNT_W           = $clog2(MAX_RES + 1);
    localparam int FIFO_DEPTH      = 16;
    localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W      = FIFO_PTR_W + 1;

    localparam logic [LINE_OUT_W-1:0] LINE_OUT_MAX = '1;
    localparam logic [UNIT_OUT_W-1:0] UNIT_OUT_MAX = '1;
    localparam logic [7:0]            DEPTH_TOP    = 8'hFF;

    localparam logic [CODE_W-1:0] CH_LF      = 21'h0000A;
    localparam logic [CODE_W-1:0] CH_DQ      = 21'h00022;
    localparam logic [CODE_W-1:0] CH_HASH    = 21'h00023;
    localparam logic [CODE_W-1:0] CH_PCT     = 21'h00025;
    localparam logic [CODE_W-1:0] CH_SQ      = 21'h00027;
    localparam logic [CODE_W-1:0] CH_LPAREN  = 21'h00028;
    localparam logic [CODE_W-1:0] CH_RPAREN  = 21'h00029;
    localparam logic [CODE_W-1:0] CH_DOT     = 21'h0002E;
    localparam logic [CODE_W-1:0] CH_COLON   = 21'h0003A;
    localparam logic [CODE_W-1:0] CH_LBRACK  = 21'h0005B;
    localparam logic [CODE_W-1:0] CH_RBRACK  = 21'h0005D;
    localparam logic [CODE_W-1:0] CH_LBRACE  = 21'h0007B;
    localparam logic [CODE_W-1:0] CH_RBRACE  = 21'h0007D;
    localparam logic [CODE_W-1:0] CH_DEGREE  = 21'h000B0;
    localparam logic [CODE_W-1:0] CH_MOD_H   = 21'h002B0;
    localparam logic [CODE_W-1:0] CH_MOD_S   = 21'h002E2;
    localparam logic [CODE_W-1:0] CH_MOD_M   = 21'h01D50;
    localparam logic [CODE_W-1:0] CH_LSINGLE = 21'h02018;
    localparam logic [CODE_W-1:0] CH_RSINGLE = 21'h02019;
    localparam logic [CODE_W-1:0] CH_LCURLY  = 21'h0201C;
    localparam logic [CODE_W-1:0] CH_RCURLY  = 21'h0201D;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_COMMENT = 10'b0000000010,
        ST_CURLY   = 10'b0000000100,
        ST_DQUOTE  = 10'b0000001000,
        ST_PAREN   = 10'b0000010000,
        ST_VERSION = 10'b0000100000,
        ST_SQUOTE  = 10'b0001000000,
        ST_BCURLY  = 10'b0010000000,
        ST_NUMBER  = 10'b0100000000,
        ST_IDENT   = 10'b1000000000
    } t_state;

    typedef enum logic [3:0] {
        TK_NONE  = 4'd0,
        TK_IDENT = 4'd1,
        TK_OP    = 4'd2,
        TK_NUM   = 4'd3,
        TK_VER   = 4'd4,
        TK_BYTE  = 4'd5,
        TK_TEXT  = 4'd6,
        TK_LBR   = 4'd7,
        TK_RBR   = 4'd8
    } t_tok;

    typedef enum logic [2:0] {
        MODE_DEC = 3'd0,
        MODE_H   = 3'd1,
        MODE_HM  = 3'd2,
        MODE_HMS = 3'd3,
        MODE_D   = 3'd4,
        MODE_DM  = 3'd5,
        MODE_DMS = 3'd6,
        MODE_ERR = 3'd7
    } t_mode;

    typedef struct packed {
        logic                  rkind;
        logic [CODE_W-1:0]     ch;
        t_tok                  tk;
        logic [LINE_OUT_W-1:0] line;
        t_mode                 mode;
        logic [UNIT_OUT_W-1:0] unit;
        logic                  last;
    } t_rec;

    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        t_rec [MAX_RES-1:0] recs;
    } t_push;

    typedef struct packed {
        t_state                     st;
        logic [7:0]                 depth;
        logic [LINE_BITS-1:0]       lc;
        logic [LINE_BITS-1:0]       tline;
        t_mode                      mode;
        logic [UNIT_COUNT_BITS-1:0] run;
        logic                       pend;
    } t_scan;

    typedef struct packed {
        logic  hit;
        t_mode need;
        t_mode nxt;
    } t_mark;

    function automatic t_scan scan_reset();
        t_scan s;
        s.st    = ST_IDLE;
        s.depth = '0;
        s.lc    = LINE_BITS'(1);
        s.tline = '0;
        s.mode  = MODE_DEC;
        s.run   = '0;
        s.pend  = 1'b0;
        return s;
    endfunction

    function automatic logic is_ws(logic [CODE_W-1:0] c);
        return c inside {[21'h09 : 21'h0D], 21'h20, 21'h85, 21'hA0};
    endfunction

    function automatic logic is_digit(logic [CODE_W-1:0] c);
        return c inside {[21'h30 : 21'h39]};
    endfunction

    function automatic logic is_letter(logic [CODE_W-1:0] c);
        return c inside {[21'h41 : 21'h5A], [21'h61 : 21'h7A], 21'hAA, 21'hB5, 21'hBA,
                         [21'hC0 : 21'hD6], [21'hD8 : 21'hF6], [21'hF8 : 21'hFF]};
    endfunction

    function automatic t_mark mark_step(logic [CODE_W-1:0] c);
        t_mark m;
        m.hit  = 1'b1;
        m.need = MODE_DEC;
        m.nxt  = MODE_DEC;
        case (c)
            CH_MOD_H:  begin m.need = MODE_DEC; m.nxt = MODE_H;   end
            CH_MOD_M:  begin m.need = MODE_H;   m.nxt = MODE_HM;  end
            CH_MOD_S:  begin m.need = MODE_HM;  m.nxt = MODE_HMS; end
            CH_DEGREE: begin m.need = MODE_DEC; m.nxt = MODE_D;   end
            CH_SQ:     begin m.need = MODE_D;   m.nxt = MODE_DM;  end
            CH_DQ:     begin m.need = MODE_DM;  m.nxt = MODE_DMS; end
            default:   m.hit = 1'b0;
        endcase
        return m;
    endfunction

    function automatic logic [LINE_OUT_W-1:0] sat_line(logic [LINE_BITS-1:0] v);
        if (33'(v) > 33'(LINE_OUT_MAX)) begin
            return LINE_OUT_MAX;
        end
        return LINE_OUT_W'(v);
    endfunction

    function automatic logic [UNIT_OUT_W-1:0] sat_unit(logic [UNIT_COUNT_BITS-1:0] v);
        if (32'(v) > 32'(UNIT_OUT_MAX)) begin
            return UNIT_OUT_MAX;
        end
        return UNIT_OUT_W'(v);
    endfunction

    function automatic t_rec mk_rec(logic rkind, logic [CODE_W-1:0] ch, t_tok tk,
                                    logic [LINE_OUT_W-1:0] line, t_mode mode,
                                    logic [UNIT_OUT_W-1:0] unit);
        t_rec r;
        r.rkind = rkind;
        r.ch    = ch;
        r.tk    = tk;
        r.line  = line;
        r.mode  = mode;
        r.unit  = unit;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic t_push add(t_push p, t_rec r);
        p.recs[p.cnt[CNT_W-2:0]] = r;
        p.cnt = p.cnt + CNT_W'(1);
        return p;
    endfunction

endpackage

@@ hdl/uts_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uts_step
// Next-state and record generation for one registered code point.
// ----------------------------------------------------------------------------
module uts_step import uts_pkg::*; (
    input  logic              i_valid,
    input  logic [CODE_W-1:0] i_code,
    input  logic              i_eoi,
    input  t_scan             i_scan,
    output t_scan             o_scan,
    output t_push             o_push
);

    t_scan              n_scan;
    t_push              push;
    logic               do_idle;
    t_mark              mark;
    t_tok               op_kind;
    logic [7:0]         dep;
    logic [CODE_W-1:0]  c;
    logic [LINE_OUT_W-1:0] tl;

    assign c    = i_code;
    assign mark = mark_step(i_code);
    assign tl   = sat_line(i_scan.tline);

    always_comb begin
        n_scan  = i_scan;
        push    = '0;
        do_idle = 1'b0;
        dep     = i_scan.depth;
        op_kind = TK_OP;
        if (i_valid) begin
            if (i_eoi) begin
                case (i_scan.st)
                    ST_CURLY, ST_DQUOTE: begin
                        push = add(push, mk_rec(1'b1, '0, TK_TEXT, tl, MODE_DEC, '0));
                    end
                    ST_PAREN: begin
                        push = add(push, mk_rec(1'b0, CH_LPAREN, TK_LBR, tl, MODE_DEC, '0));
                        push = add(push, mk_rec(1'b1, '0, TK_LBR, tl, MODE_DEC, '0));
                    end
                    ST_VERSION: begin
                        if (i_scan.pend) begin
                            push = add(push, mk_rec(1'b0, CH_PCT, TK_VER, tl, MODE_DEC, '0));
                        end
                        push = add(push, mk_rec(1'b1, '0, TK_VER, tl, MODE_DEC, '0));
                    end
                    ST_SQUOTE, ST_BCURLY: begin
                        push = add(push, mk_rec(1'b1, '0, TK_BYTE, tl, MODE_DEC, '0));
                    end
                    ST_NUMBER: begin
                        push = add(push, mk_rec(1'b1, '0, TK_NUM, tl, i_scan.mode,
                                                sat_unit(i_scan.run)));
                    end
                    ST_IDENT: begin
                        push = add(push, mk_rec(1'b1, '0, TK_IDENT, tl, MODE_DEC, '0));
                    end
                    default: ;
                endcase
                push   = add(push, mk_rec(1'b1, '0, TK_NONE, sat_line(i_scan.lc),
                                          MODE_DEC, '0));
                n_scan = scan_reset();
            end else begin
                case (i_scan.st)
                    ST_COMMENT: begin
                        if (c == CH_LF) n_scan.st = ST_IDLE;
                    end
                    ST_CURLY: begin
                        if (c == CH_LCURLY) begin
                            if (i_scan.depth != DEPTH_TOP) begin
                                n_scan.depth = i_scan.depth + 8'd1;
                            end
                            push = add(push, mk_rec(1'b0, c, TK_TEXT, tl, MODE_DEC, '0));
                        end else if (c == CH_RCURLY) begin
                            if (i_scan.depth != 8'd0) dep = i_scan.depth - 8'd1;
                            n_scan.depth = dep;
                            if (dep == 8'd0) begin
                                push = add(push, mk_rec(1'b1, '0, TK_TEXT, tl, MODE_DEC, '0));
                                n_scan.st = ST_IDLE;
                            end else begin
                                push = add(push, mk_rec(1'b0, c, TK_TEXT, tl, MODE_DEC, '0));
                            end
                        end else begin
                            push = add(push, mk_rec(1'b0, c, TK_TEXT, tl, MODE_DEC, '0));
                        end
                    end
                    ST_DQUOTE: begin
                        if (c == CH_DQ) begin
                            push = add(push, mk_rec(1'b1, '0, TK_TEXT, tl, MODE_DEC, '0));
                            n_scan.st = ST_IDLE;
                        end else begin
                            push = add(push, mk_rec(1'b0, c, TK_TEXT, tl, MODE_DEC, '0));
                        end
                    end
                    ST_PAREN: begin
                        if (c == CH_PCT) begin
                            n_scan.st   = ST_VERSION;
                            n_scan.pend = 1'b0;
                        end else begin
                            push = add(push, mk_rec(1'b0, CH_LPAREN, TK_LBR, tl, MODE_DEC, '0));
                            push = add(push, mk_rec(1'b1, '0, TK_LBR, tl, MODE_DEC, '0));
                            do_idle = 1'b1;
                        end
                    end
                    ST_VERSION: begin
                        if (i_scan.pend && c == CH_RPAREN) begin
                            n_scan.pend = 1'b0;
                            push = add(push, mk_rec(1'b1, '0, TK_VER, tl, MODE_DEC, '0));
                            n_scan.st = ST_IDLE;
                        end else begin
                            if (i_scan.pend) begin
                                push = add(push, mk_rec(1'b0, CH_PCT, TK_VER, tl, MODE_DEC, '0));
                            end
                            if (c == CH_PCT) begin
                                n_scan.pend = 1'b1;
                            end else begin
                                n_scan.pend = 1'b0;
                                push = add(push, mk_rec(1'b0, c, TK_VER, tl, MODE_DEC, '0));
                            end
                        end
                    end
                    ST_SQUOTE, ST_BCURLY: begin
                        if ((i_scan.st == ST_SQUOTE && c == CH_SQ) ||
                            (i_scan.st == ST_BCURLY && c == CH_RSINGLE)) begin
                            push = add(push, mk_rec(1'b1, '0, TK_BYTE, tl, MODE_DEC, '0));
                            n_scan.st = ST_IDLE;
                        end else begin
                            push = add(push, mk_rec(1'b0, CODE_W'(c[7:0]), TK_BYTE, tl,
                                                    MODE_DEC, '0));
                        end
                    end
                    ST_NUMBER: begin
                        if (is_digit(c) || c == CH_DOT) begin
                            n_scan.run = '0;
                            push = add(push, mk_rec(1'b0, c, TK_NUM, tl, MODE_DEC, '0));
                        end else if (is_letter(c)) begin
                            if (i_scan.run != '1) begin
                                n_scan.run = i_scan.run + UNIT_COUNT_BITS'(1);
                            end
                            push = add(push, mk_rec(1'b0, c, TK_NUM, tl, MODE_DEC, '0));
                        end else if (mark.hit) begin
                            n_scan.run = '0;
                            if (i_scan.mode != MODE_ERR && i_scan.mode == mark.need) begin
                                n_scan.mode = mark.nxt;
                                push = add(push, mk_rec(1'b0, CH_COLON, TK_NUM, tl,
                                                        MODE_DEC, '0));
                            end else begin
                                n_scan.mode = MODE_ERR;
                                push = add(push, mk_rec(1'b0, c, TK_NUM, tl, MODE_DEC, '0));
                            end
                        end else begin
                            push = add(push, mk_rec(1'b1, '0, TK_NUM, tl, i_scan.mode,
                                                    sat_unit(i_scan.run)));
                            do_idle = 1'b1;
                        end
                    end
                    ST_IDENT: begin
                        if (is_letter(c) || is_digit(c)) begin
                            push = add(push, mk_rec(1'b0, c, TK_IDENT, tl, MODE_DEC, '0));
                        end else begin
                            push = add(push, mk_rec(1'b1, '0, TK_IDENT, tl, MODE_DEC, '0));
                            do_idle = 1'b1;
                        end
                    end
                    default: do_idle = 1'b1;
                endcase

                // start of a new item, also after a token closed by lookahead
                if (do_idle) begin
                    n_scan.st = ST_IDLE;
                    if (!is_ws(c)) begin
                        if (c == CH_HASH) begin
                            n_scan.st = ST_COMMENT;
                        end else begin
                            n_scan.tline = i_scan.lc;
                            if (c == CH_LCURLY) begin
                                n_scan.st    = ST_CURLY;
                                n_scan.depth = 8'd1;
                            end else if (c == CH_DQ) begin
                                n_scan.st = ST_DQUOTE;
                            end else if (c == CH_LPAREN) begin
                                n_scan.st = ST_PAREN;
                            end else if (c == CH_SQ) begin
                                n_scan.st = ST_SQUOTE;
                            end else if (c == CH_LSINGLE) begin
                                n_scan.st = ST_BCURLY;
                            end else if (is_digit(c)) begin
                                n_scan.st   = ST_NUMBER;
                                n_scan.mode = MODE_DEC;
                                n_scan.run  = '0;
                                push = add(push, mk_rec(1'b0, c, TK_NUM, sat_line(i_scan.lc),
                                                        MODE_DEC, '0));
                            end else if (is_letter(c)) begin
                                n_scan.st = ST_IDENT;
                                push = add(push, mk_rec(1'b0, c, TK_IDENT,
                                                        sat_line(i_scan.lc), MODE_DEC, '0));
                            end else begin
                                if (c == CH_LBRACE || c == CH_LBRACK) begin
                                    op_kind = TK_LBR;
                                end else if (c == CH_RBRACE || c == CH_RBRACK ||
                                             c == CH_RPAREN) begin
                                    op_kind = TK_RBR;
                                end
                                push = add(push, mk_rec(1'b0, c, op_kind, sat_line(i_scan.lc),
                                                        MODE_DEC, '0));
                                push = add(push, mk_rec(1'b1, '0, op_kind, sat_line(i_scan.lc),
                                                        MODE_DEC, '0));
                            end
                        end
                    end
                end

                if (c == CH_LF && i_scan.lc != '1) begin
                    n_scan.lc = i_scan.lc + LINE_BITS'(1);
                end
            end
        end

        for (int i = 0; i < MAX_RES; i++) begin
            push.recs[i].last = (CNT_W'(i) == push.cnt - CNT_W'(1));
        end
    end

    assign o_scan = n_scan;
    assign o_push = push;

endmodule

@@ hdl/uts_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uts_fifo
// Result queue: up to four records in a cycle, one out a cycle when i_tready.
// ----------------------------------------------------------------------------
module uts_fifo import uts_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_tready,
    output logic  o_tvalid,
    output t_rec  o_rec,
    output logic  o_space_ok
);

    t_rec                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  pop;

    assign o_tvalid   = (r_count != '0);
    assign pop        = o_tvalid && i_tready;
    assign o_rec      = r_mem[r_rd_ptr];
    // room for the record group in the input stage plus one more group
    assign o_space_ok = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2 * MAX_RES));

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (CNT_W'(i) < i_push.cnt) begin
                r_mem[r_wr_ptr + FIFO_PTR_W'(i)] <= i_push.recs[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(i_push.cnt);
            r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(pop);
            r_count  <= r_count + FIFO_CNT_W'(i_push.cnt) - FIFO_CNT_W'(pop);
        end
    end

endmodule

@@ hdl/unicode_token_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unicode_token_scanner
// Streaming lexer: one code point in, token content and end records out.
// ----------------------------------------------------------------------------
// The scanner takes one code point per clock cycle while s_axis_tready is high;
// s_axis_tlast marks end of text. The code point is registered, then one pass of
// logic updates the scan state and produces zero to four records, which enter a
// 16-entry result queue. Records leave at one per cycle while m_axis_tready is
// high, so the sustained input rate is one item per cycle while items average
// at most one record; s_axis_tready falls when the queue holds more than eight
// records, and stays low during reset. An item's first record is offered after
// the input register and the queue. No clearing pass after reset.
// ----------------------------------------------------------------------------
module unicode_token_scanner import uts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [20:0] code_point, [23:21] zero
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [20:0] char_value, [36:21] start_line,
                                        // [39:37] number_mode, [47:40] unit_length
    output logic [4:0]  m_axis_tuser,   // [0] record_kind, [4:1] token_kind
    output logic        m_axis_tlast    // last
);

    logic              r_in_valid;
    logic [CODE_W-1:0] r_code;
    logic              r_eoi;
    t_scan             r_scan;
    t_scan             n_scan;
    t_push             push;
    t_rec              rec;
    logic              space_ok;
    logic              accept;

    assign s_axis_tready = space_ok && i_rst_n;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_code <= s_axis_tdata[CODE_W-1:0];
            r_eoi  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= scan_reset();
        end else begin
            r_scan <= n_scan;
        end
    end

    uts_step u_step (
        .i_valid (r_in_valid),
        .i_code  (r_code),
        .i_eoi   (r_eoi),
        .i_scan  (r_scan),
        .o_scan  (n_scan),
        .o_push  (push)
    );

    uts_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_tready   (m_axis_tready),
        .o_tvalid   (m_axis_tvalid),
        .o_rec      (rec),
        .o_space_ok (space_ok)
    );

    assign m_axis_tdata = {rec.unit, rec.mode, rec.line, rec.ch};
    assign m_axis_tuser = {rec.tk, rec.rkind};
    assign m_axis_tlast = rec.last;

endmodule
